>>> rtl/aabb_pkg.sv
// ============================================================================
// aabb_pkg: shared types and constants for the box transform
// fixed point formats, pipeline word layouts and operation codes
// ============================================================================
`timescale 1ns / 1ps

package aabb_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_AXES    = 3;
    localparam int ROW_W       = 2;

    localparam int PROD_W  = 2 * COORD_WIDTH;
    localparam int TRANS_W = COORD_WIDTH + FRAC_BITS;
    // headroom for three products plus the shifted translation
    localparam int SUM_W   = ((PROD_W > TRANS_W) ? PROD_W : TRANS_W) + 3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_BOX  = 1'b1;

    localparam logic [ROW_W-1:0] ROW_NONE = ROW_W'(NUM_AXES);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SUM_W-1:0]       sum_t;

    localparam coord_t COEF_ONE  = coord_t'(64'd1 << FRAC_BITS);
    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // one matrix row: x, y, z weights and translation
    typedef struct packed {
        coord_t                tr;
        coord_t [NUM_AXES-1:0] w;
    } row_t;

    typedef struct packed {
        coord_t [NUM_AXES-1:0] hi;
        coord_t [NUM_AXES-1:0] lo;
    } box_t;

    typedef struct packed {
        prod_t p;
        prod_t q;
    } pair_t;

    // products of every weight with both box corners
    typedef struct packed {
        pair_t  [NUM_AXES-1:0][NUM_AXES-1:0] pq;
        coord_t [NUM_AXES-1:0]               tr;
    } prod_word_t;

    typedef struct packed {
        prod_t  [NUM_AXES-1:0][NUM_AXES-1:0] lo_term;
        prod_t  [NUM_AXES-1:0][NUM_AXES-1:0] hi_term;
        coord_t [NUM_AXES-1:0]               tr;
    } sort_word_t;

    typedef struct packed {
        sum_t [NUM_AXES-1:0] mn;
        sum_t [NUM_AXES-1:0] mx;
    } sum_word_t;

    typedef struct packed {
        coord_t [NUM_AXES-1:0] mn;
        coord_t [NUM_AXES-1:0] mx;
        logic                  sat;
    } result_t;

endpackage

>>> rtl/aabb_coef_regs.sv
// ============================================================================
// aabb_coef_regs: affine matrix storage
// three rows of weights and translation, identity after reset
// ============================================================================
`timescale 1ns / 1ps

module aabb_coef_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [aabb_pkg::ROW_W-1:0]        wr_row,
    input  aabb_pkg::row_t                    wr_data,
    output aabb_pkg::row_t [aabb_pkg::NUM_AXES-1:0] coef
);

    aabb_pkg::row_t [aabb_pkg::NUM_AXES-1:0] coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < aabb_pkg::NUM_AXES; i++) begin
                coef_reg[i].tr <= '0;
                for (int j = 0; j < aabb_pkg::NUM_AXES; j++) begin
                    coef_reg[i].w[j] <= (i == j) ? aabb_pkg::COEF_ONE : '0;
                end
            end
        end else if (wr_en) begin
            coef_reg[wr_row] <= wr_data;
        end
    end

    assign coef = coef_reg;

endmodule

>>> rtl/aabb_mul_stage.sv
// ============================================================================
// aabb_mul_stage: product stage
// multiplies each weight with the min and max corner coordinate
// ============================================================================
`timescale 1ns / 1ps

module aabb_mul_stage (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  aabb_pkg::box_t                          box,
    input  aabb_pkg::row_t [aabb_pkg::NUM_AXES-1:0] coef,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output aabb_pkg::prod_word_t                    out_word
);

    aabb_pkg::prod_word_t word_next;
    aabb_pkg::prod_word_t word_reg;
    logic                 valid_reg;

    always_comb begin
        for (int i = 0; i < aabb_pkg::NUM_AXES; i++) begin
            word_next.tr[i] = coef[i].tr;
            for (int j = 0; j < aabb_pkg::NUM_AXES; j++) begin
                word_next.pq[i][j].p = $signed(coef[i].w[j]) * $signed(box.lo[j]);
                word_next.pq[i][j].q = $signed(coef[i].w[j]) * $signed(box.hi[j]);
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> rtl/aabb_sort_sum.sv
// ============================================================================
// aabb_sort_sum: sort and accumulate stages
// orders each product pair, then sums translation and terms per axis
// ============================================================================
`timescale 1ns / 1ps

module aabb_sort_sum (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  aabb_pkg::prod_word_t  in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output aabb_pkg::sum_word_t   out_word
);

    aabb_pkg::sort_word_t sort_next;
    aabb_pkg::sort_word_t sort_reg;
    logic                 sort_valid_reg;
    logic                 sort_ready;

    aabb_pkg::sum_word_t  sum_next;
    aabb_pkg::sum_word_t  sum_reg;
    logic                 sum_valid_reg;
    logic                 sum_ready;

    // per weight: the smaller product feeds the min sum, the larger the max sum
    always_comb begin
        for (int i = 0; i < aabb_pkg::NUM_AXES; i++) begin
            sort_next.tr[i] = in_word.tr[i];
            for (int j = 0; j < aabb_pkg::NUM_AXES; j++) begin
                if ($signed(in_word.pq[i][j].q) < $signed(in_word.pq[i][j].p)) begin
                    sort_next.lo_term[i][j] = in_word.pq[i][j].q;
                    sort_next.hi_term[i][j] = in_word.pq[i][j].p;
                end else begin
                    sort_next.lo_term[i][j] = in_word.pq[i][j].p;
                    sort_next.hi_term[i][j] = in_word.pq[i][j].q;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < aabb_pkg::NUM_AXES; i++) begin
            sum_next.mn[i] =
                (aabb_pkg::sum_t'($signed(sort_reg.tr[i])) <<< aabb_pkg::FRAC_BITS)
                + aabb_pkg::sum_t'($signed(sort_reg.lo_term[i][0]))
                + aabb_pkg::sum_t'($signed(sort_reg.lo_term[i][1]))
                + aabb_pkg::sum_t'($signed(sort_reg.lo_term[i][2]));
            sum_next.mx[i] =
                (aabb_pkg::sum_t'($signed(sort_reg.tr[i])) <<< aabb_pkg::FRAC_BITS)
                + aabb_pkg::sum_t'($signed(sort_reg.hi_term[i][0]))
                + aabb_pkg::sum_t'($signed(sort_reg.hi_term[i][1]))
                + aabb_pkg::sum_t'($signed(sort_reg.hi_term[i][2]));
        end
    end

    assign sum_ready  = !sum_valid_reg || out_ready;
    assign sort_ready = !sort_valid_reg || sum_ready;
    assign in_ready   = sort_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sort_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end else begin
            if (sort_ready) begin
                sort_valid_reg <= in_valid;
            end
            if (sum_ready) begin
                sum_valid_reg <= sort_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sort_ready && in_valid) begin
            sort_reg <= sort_next;
        end
        if (sum_ready && sort_valid_reg) begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_word  = sum_reg;

`ifndef SYNTH
    a_sum_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_valid_reg |-> ($signed(sum_reg.mn[0]) <= $signed(sum_reg.mx[0]))
                       && ($signed(sum_reg.mn[1]) <= $signed(sum_reg.mx[1]))
                       && ($signed(sum_reg.mn[2]) <= $signed(sum_reg.mx[2])))
        else $error("min sum above max sum");
`endif

endmodule

>>> rtl/aabb_finish.sv
// ============================================================================
// aabb_finish: output stage
// floor shift to the coordinate format, clamp, result register
// ============================================================================
`timescale 1ns / 1ps

module aabb_finish (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aabb_pkg::sum_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aabb_pkg::result_t    out_word
);

    aabb_pkg::result_t res_next;
    aabb_pkg::result_t res_reg;
    logic              valid_reg;

    // returns {clamped, value}
    function automatic logic [aabb_pkg::COORD_WIDTH:0] clamp(input aabb_pkg::sum_t v);
        aabb_pkg::sum_t                                   sh;
        logic [aabb_pkg::SUM_W-aabb_pkg::COORD_WIDTH:0]   upper;
        sh    = v >>> aabb_pkg::FRAC_BITS;
        upper = sh[aabb_pkg::SUM_W-1:aabb_pkg::COORD_WIDTH-1];
        if ((&upper) || !(|upper)) begin
            clamp = {1'b0, sh[aabb_pkg::COORD_WIDTH-1:0]};
        end else if (sh[aabb_pkg::SUM_W-1]) begin
            clamp = {1'b1, aabb_pkg::COORD_MIN};
        end else begin
            clamp = {1'b1, aabb_pkg::COORD_MAX};
        end
    endfunction

    always_comb begin
        logic [aabb_pkg::COORD_WIDTH:0] c_mn;
        logic [aabb_pkg::COORD_WIDTH:0] c_mx;
        res_next.sat = 1'b0;
        for (int i = 0; i < aabb_pkg::NUM_AXES; i++) begin
            c_mn = clamp(in_word.mn[i]);
            c_mx = clamp(in_word.mx[i]);
            res_next.mn[i] = c_mn[aabb_pkg::COORD_WIDTH-1:0];
            res_next.mx[i] = c_mx[aabb_pkg::COORD_WIDTH-1:0];
            res_next.sat   = res_next.sat | c_mn[aabb_pkg::COORD_WIDTH]
                                          | c_mx[aabb_pkg::COORD_WIDTH];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = res_reg;

`ifndef SYNTH
    a_box_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ($signed(res_reg.mn[0]) <= $signed(res_reg.mx[0]))
                   && ($signed(res_reg.mn[1]) <= $signed(res_reg.mx[1]))
                   && ($signed(res_reg.mn[2]) <= $signed(res_reg.mx[2])))
        else $error("result box min above max");

    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && res_reg.sat) |->
            (res_reg.mn[0] == aabb_pkg::COORD_MIN) || (res_reg.mn[0] == aabb_pkg::COORD_MAX)
         || (res_reg.mn[1] == aabb_pkg::COORD_MIN) || (res_reg.mn[1] == aabb_pkg::COORD_MAX)
         || (res_reg.mn[2] == aabb_pkg::COORD_MIN) || (res_reg.mn[2] == aabb_pkg::COORD_MAX)
         || (res_reg.mx[0] == aabb_pkg::COORD_MIN) || (res_reg.mx[0] == aabb_pkg::COORD_MAX)
         || (res_reg.mx[1] == aabb_pkg::COORD_MIN) || (res_reg.mx[1] == aabb_pkg::COORD_MAX)
         || (res_reg.mx[2] == aabb_pkg::COORD_MIN) || (res_reg.mx[2] == aabb_pkg::COORD_MAX))
        else $error("saturation flag without a clamped coordinate");
`endif

endmodule

>>> rtl/aabb_affine_transform.sv
// ============================================================================
// aabb_affine_transform: affine transform of an axis-aligned box
// pipeline: an accepted box word passes these registers before its result word is valid
//   (registers for products, min/max sort, sums, clamp; products load at the accept)
// throughput: one word per cycle while the result side is not stalled; the 18 parallel 32x32 products set the pace
// load words update the matrix at their accepting edge and return nothing
// reset: synchronous active low, empties the pipeline and restores identity
// ============================================================================
`timescale 1ns / 1ps

module aabb_affine_transform (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_operation,
    input  logic [aabb_pkg::ROW_W-1:0]   s_row_index,
    input  aabb_pkg::coord_t             s_value_a,
    input  aabb_pkg::coord_t             s_value_b,
    input  aabb_pkg::coord_t             s_value_c,
    input  aabb_pkg::coord_t             s_value_d,
    input  aabb_pkg::coord_t             s_value_e,
    input  aabb_pkg::coord_t             s_value_f,

    output logic                         m_valid,
    input  logic                         m_ready,
    output aabb_pkg::coord_t             m_out_min_x,
    output aabb_pkg::coord_t             m_out_min_y,
    output aabb_pkg::coord_t             m_out_min_z,
    output aabb_pkg::coord_t             m_out_max_x,
    output aabb_pkg::coord_t             m_out_max_y,
    output aabb_pkg::coord_t             m_out_max_z,
    output logic                         m_saturated
);

    aabb_pkg::row_t [aabb_pkg::NUM_AXES-1:0] coef;
    aabb_pkg::row_t                          load_row;
    aabb_pkg::box_t                          box;
    logic                                    load_we;
    logic                                    box_valid;

    logic                  mul_ready;
    logic                  prod_valid;
    logic                  prod_ready;
    aabb_pkg::prod_word_t  prod_word;
    logic                  sum_valid;
    logic                  sum_ready;
    aabb_pkg::sum_word_t   sum_word;
    aabb_pkg::result_t     result;

    assign s_ready = mul_ready;

    // loads bypass the pipeline: boxes taken later see the new row
    assign load_we   = s_valid && s_ready && (s_operation == aabb_pkg::OP_LOAD)
                       && (s_row_index != aabb_pkg::ROW_NONE);
    assign box_valid = s_valid && (s_operation == aabb_pkg::OP_BOX);

    always_comb begin
        load_row.w[0] = s_value_a;
        load_row.w[1] = s_value_b;
        load_row.w[2] = s_value_c;
        load_row.tr   = s_value_d;
        box.lo[0]     = s_value_a;
        box.lo[1]     = s_value_b;
        box.lo[2]     = s_value_c;
        box.hi[0]     = s_value_d;
        box.hi[1]     = s_value_e;
        box.hi[2]     = s_value_f;
    end

    aabb_coef_regs u_coef (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (load_we),
        .wr_row  (s_row_index),
        .wr_data (load_row),
        .coef    (coef)
    );

    aabb_mul_stage u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (box_valid),
        .in_ready  (mul_ready),
        .box       (box),
        .coef      (coef),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_word  (prod_word)
    );

    aabb_sort_sum u_sort_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_word   (prod_word),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_word  (sum_word)
    );

    aabb_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_word   (sum_word),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (result)
    );

    assign m_out_min_x = result.mn[0];
    assign m_out_min_y = result.mn[1];
    assign m_out_min_z = result.mn[2];
    assign m_out_max_x = result.mx[0];
    assign m_out_max_y = result.mx[1];
    assign m_out_max_z = result.mx[2];
    assign m_saturated = result.sat;

`ifndef SYNTH
    a_ready_follows_sink: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while result side is ready");

    a_row_none_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_operation == aabb_pkg::OP_LOAD)
         && (s_row_index == aabb_pkg::ROW_NONE)) |=> $stable(coef))
        else $error("load to unused row changed the matrix");
`endif

endmodule

>>> sim/tb_top.sv
// ============================================================================
// tb_top: testbench for the affine box transform
// a queue-fed driver pushes matrix row loads and box words into the block;
// each accepted word updates a local copy of the matrix or predicts the
// enclosing box with exact wide arithmetic, floor shift and clamping, and a
// monitor checks every result word against the oldest prediction
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic                          op;
        logic [aabb_pkg::ROW_W-1:0]    row;
        aabb_pkg::coord_t [5:0]        val;
    } stim_word_t;

    typedef logic signed [127:0] wide_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    stim_word_t        bus_word = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    aabb_pkg::coord_t  m_out_min_x, m_out_min_y, m_out_min_z;
    aabb_pkg::coord_t  m_out_max_x, m_out_max_y, m_out_max_z;
    logic              m_saturated;

    stim_word_t        pending_words[$];
    aabb_pkg::result_t expected_bounds[$];
    aabb_pkg::coord_t  matrix_coeffs[12];
    stim_word_t        next_word;
    aabb_pkg::result_t got_bounds, want_bounds;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int unsigned       failures = 0;

    always #2 aclk = ~aclk;

    aabb_affine_transform u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (bus_word.op),
        .s_row_index (bus_word.row),
        .s_value_a   (bus_word.val[0]),
        .s_value_b   (bus_word.val[1]),
        .s_value_c   (bus_word.val[2]),
        .s_value_d   (bus_word.val[3]),
        .s_value_e   (bus_word.val[4]),
        .s_value_f   (bus_word.val[5]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_min_x (m_out_min_x),
        .m_out_min_y (m_out_min_y),
        .m_out_min_z (m_out_min_z),
        .m_out_max_x (m_out_max_x),
        .m_out_max_y (m_out_max_y),
        .m_out_max_z (m_out_max_z),
        .m_saturated (m_saturated)
    );

    // floor shift to the coordinate format, then clamp
    function automatic aabb_pkg::coord_t clamp_coord(input wide_t acc, inout logic sat);
        wide_t v;
        wide_t top;
        wide_t bot;
        v   = acc >>> aabb_pkg::FRAC_BITS;
        top = signed'(aabb_pkg::COORD_MAX);
        bot = signed'(aabb_pkg::COORD_MIN);
        if (v > top) begin
            sat = 1'b1;
            return aabb_pkg::COORD_MAX;
        end
        if (v < bot) begin
            sat = 1'b1;
            return aabb_pkg::COORD_MIN;
        end
        return aabb_pkg::coord_t'(v[aabb_pkg::COORD_WIDTH-1:0]);
    endfunction

    // applies one accepted word to the matrix copy or predicts its bounds
    function automatic void predict_bounds(input stim_word_t w);
        wide_t             acc_lo, acc_hi, wt, lo_v, hi_v, p, q;
        logic              sat;
        aabb_pkg::result_t r;
        if (w.op == aabb_pkg::OP_LOAD) begin
            if (w.row != aabb_pkg::ROW_NONE) begin
                for (int j = 0; j < 4; j++) matrix_coeffs[w.row * 4 + j] = w.val[j];
            end
            return;
        end
        sat = 1'b0;
        for (int i = 0; i < aabb_pkg::NUM_AXES; i++) begin
            wt     = signed'(matrix_coeffs[i * 4 + 3]);
            acc_lo = wt <<< aabb_pkg::FRAC_BITS;
            acc_hi = acc_lo;
            for (int j = 0; j < aabb_pkg::NUM_AXES; j++) begin
                wt   = signed'(matrix_coeffs[i * 4 + j]);
                lo_v = signed'(w.val[j]);
                hi_v = signed'(w.val[3 + j]);
                p    = wt * lo_v;
                q    = wt * hi_v;
                if (q < p) begin
                    acc_lo = acc_lo + q;
                    acc_hi = acc_hi + p;
                end else begin
                    acc_lo = acc_lo + p;
                    acc_hi = acc_hi + q;
                end
            end
            r.mn[i] = clamp_coord(acc_lo, sat);
            r.mx[i] = clamp_coord(acc_hi, sat);
        end
        r.sat = sat;
        expected_bounds.push_back(r);
    endfunction

    function automatic void push_load(input logic [aabb_pkg::ROW_W-1:0] row,
                                      input aabb_pkg::coord_t wx, input aabb_pkg::coord_t wy,
                                      input aabb_pkg::coord_t wz, input aabb_pkg::coord_t tr);
        stim_word_t w;
        w.op  = aabb_pkg::OP_LOAD;
        w.row = row;
        w.val = {aabb_pkg::coord_t'($urandom), aabb_pkg::coord_t'($urandom), tr, wz, wy, wx};
        pending_words.push_back(w);
    endfunction

    function automatic void push_box(input aabb_pkg::coord_t lx, input aabb_pkg::coord_t ly,
                                     input aabb_pkg::coord_t lz, input aabb_pkg::coord_t hx,
                                     input aabb_pkg::coord_t hy, input aabb_pkg::coord_t hz);
        stim_word_t w;
        w.op  = aabb_pkg::OP_BOX;
        w.row = aabb_pkg::ROW_W'($urandom_range(0, 3));
        w.val = {hz, hy, hx, lz, ly, lx};
        pending_words.push_back(w);
    endfunction

    // mostly values within +-2^bits, with some full-range and corner values
    function automatic aabb_pkg::coord_t rand_coord(input int bits);
        aabb_pkg::coord_t v;
        int               pick;
        pick = $urandom_range(0, 99);
        v    = $urandom;
        if (pick < 8) return v;
        if (pick < 14) begin
            case ($urandom_range(0, 5))
                0: return aabb_pkg::COORD_MIN;
                1: return aabb_pkg::COORD_MAX;
                2: return '0;
                3: return aabb_pkg::coord_t'(-1);
                4: return aabb_pkg::COEF_ONE;
                default: return -aabb_pkg::COEF_ONE;
            endcase
        end
        return v >>> (31 - bits);
    endfunction

    task automatic fill_random(input int count);
        int               n;
        int               roll;
        int               bits;
        aabb_pkg::coord_t a, b;
        aabb_pkg::coord_t lo[3], hi[3];
        n = 0;
        while (n < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                // fresh matrix, then boxes follow
                for (int r = 0; r < aabb_pkg::NUM_AXES; r++) begin
                    push_load(aabb_pkg::ROW_W'(r), rand_coord($urandom_range(10, 19)),
                              rand_coord($urandom_range(10, 19)),
                              rand_coord($urandom_range(10, 19)),
                              rand_coord($urandom_range(12, 28)));
                end
                n += 3;
            end else if (roll < 14) begin
                push_load(aabb_pkg::ROW_W'($urandom_range(0, 3)),
                          rand_coord($urandom_range(10, 19)),
                          rand_coord($urandom_range(10, 19)),
                          rand_coord($urandom_range(10, 19)),
                          rand_coord($urandom_range(12, 28)));
                n++;
            end else if (roll < 16) begin
                // put one row back to identity
                case ($urandom_range(0, 2))
                    0: push_load(aabb_pkg::ROW_W'(0), aabb_pkg::COEF_ONE, '0, '0, '0);
                    1: push_load(aabb_pkg::ROW_W'(1), '0, aabb_pkg::COEF_ONE, '0, '0);
                    default: push_load(aabb_pkg::ROW_W'(2), '0, '0, aabb_pkg::COEF_ONE, '0);
                endcase
                n++;
            end else begin
                for (int j = 0; j < 3; j++) begin
                    bits = $urandom_range(8, 28);
                    a    = rand_coord(bits);
                    b    = rand_coord(bits);
                    if (roll < 84 && a > b) begin
                        lo[j] = b;
                        hi[j] = a;
                    end else begin
                        lo[j] = a;
                        hi[j] = b;
                    end
                end
                push_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
                n++;
            end
        end
    endtask

    task automatic drain();
        int n;
        while (pending_words.size() != 0 || s_valid) @(posedge aclk);
        for (n = 0; n < 1000 && expected_bounds.size() != 0; n++) @(posedge aclk);
    endtask

    // driver: presents the next pending word, holds it until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_bounds(bus_word);
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_word = pending_words.pop_front();
                    bus_word <= next_word;
                    s_valid  <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure and result check
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            got_bounds.mn[0] = m_out_min_x;
            got_bounds.mn[1] = m_out_min_y;
            got_bounds.mn[2] = m_out_min_z;
            got_bounds.mx[0] = m_out_max_x;
            got_bounds.mx[1] = m_out_max_y;
            got_bounds.mx[2] = m_out_max_z;
            got_bounds.sat   = m_saturated;
            if (expected_bounds.size() == 0) begin
                failures++;
                if (failures <= 10) $display("result word with no box pending: %h", got_bounds);
            end else begin
                want_bounds = expected_bounds.pop_front();
                if (got_bounds !== want_bounds) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("mismatch: want min %h %h %h max %h %h %h sat %b",
                                 want_bounds.mn[0], want_bounds.mn[1], want_bounds.mn[2],
                                 want_bounds.mx[0], want_bounds.mx[1], want_bounds.mx[2],
                                 want_bounds.sat);
                        $display("          got  min %h %h %h max %h %h %h sat %b",
                                 got_bounds.mn[0], got_bounds.mn[1], got_bounds.mn[2],
                                 got_bounds.mx[0], got_bounds.mx[1], got_bounds.mx[2],
                                 got_bounds.sat);
                    end
                end
            end
        end
    end

    initial begin
        for (int k = 0; k < 12; k++) matrix_coeffs[k] = '0;
        matrix_coeffs[0]  = aabb_pkg::COEF_ONE;
        matrix_coeffs[5]  = aabb_pkg::COEF_ONE;
        matrix_coeffs[10] = aabb_pkg::COEF_ONE;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        send_idle_pct  = 20;
        recv_stall_pct = 52;
        // identity passes the full coordinate range through unchanged
        push_box(aabb_pkg::COORD_MIN, aabb_pkg::COORD_MIN, aabb_pkg::COORD_MIN,
                 aabb_pkg::COORD_MAX, aabb_pkg::COORD_MAX, aabb_pkg::COORD_MAX);
        // inverted box: min corner above max corner on some axes
        push_box(32'sh0005_0000, -32'sh0003_0000, 32'sh0000_0000,
                 -32'sh0002_0000, 32'sh0007_8000, -32'sh0000_0001);
        // load to row three must leave the matrix alone
        push_load(aabb_pkg::ROW_NONE, aabb_pkg::COORD_MAX, aabb_pkg::COORD_MAX,
                  aabb_pkg::COORD_MAX, aabb_pkg::COORD_MAX);
        push_box(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                 32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000);
        push_load(aabb_pkg::ROW_W'(0), aabb_pkg::COORD_MAX, aabb_pkg::COORD_MIN, '0,
                  aabb_pkg::COORD_MAX);
        push_load(aabb_pkg::ROW_W'(1), aabb_pkg::COORD_MIN, aabb_pkg::COORD_MIN,
                  aabb_pkg::COORD_MIN, aabb_pkg::COORD_MIN);
        push_load(aabb_pkg::ROW_W'(2), -aabb_pkg::COEF_ONE, 32'sh0000_8000, 32'sh0002_0000, '0);
        push_box(aabb_pkg::COORD_MIN, aabb_pkg::COORD_MIN, aabb_pkg::COORD_MIN,
                 aabb_pkg::COORD_MAX, aabb_pkg::COORD_MAX, aabb_pkg::COORD_MAX);
        push_box('0, '0, '0, '0, '0, '0);
        push_box(aabb_pkg::coord_t'(-1), aabb_pkg::coord_t'(-1), aabb_pkg::coord_t'(-1),
                 32'sd1, 32'sd1, 32'sd1);
        push_box(aabb_pkg::COORD_MAX, aabb_pkg::COORD_MAX, aabb_pkg::COORD_MAX,
                 aabb_pkg::COORD_MIN, aabb_pkg::COORD_MIN, aabb_pkg::COORD_MIN);
        // tiny weights and translations exercise the floor shift
        push_load(aabb_pkg::ROW_W'(0), aabb_pkg::COEF_ONE, '0, '0, aabb_pkg::coord_t'(-1));
        push_load(aabb_pkg::ROW_W'(1), '0, -aabb_pkg::COEF_ONE, '0, 32'sh0000_8000);
        push_load(aabb_pkg::ROW_W'(2), '0, '0, 32'sd1, 32'sh7fff_0000);
        push_box(-32'sd3, -32'sd3, -32'sd3, 32'sd3, 32'sd3, 32'sd3);
        push_box(aabb_pkg::COORD_MIN, aabb_pkg::COORD_MIN, aabb_pkg::COORD_MIN,
                 aabb_pkg::COORD_MAX, aabb_pkg::COORD_MAX, aabb_pkg::COORD_MAX);
        push_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        push_load(aabb_pkg::ROW_W'(0), aabb_pkg::COEF_ONE, '0, '0, '0);
        push_load(aabb_pkg::ROW_W'(1), '0, aabb_pkg::COEF_ONE, '0, '0);
        push_load(aabb_pkg::ROW_W'(2), '0, '0, aabb_pkg::COEF_ONE, '0);
        push_box(-32'sh0000_0001, 32'sh1234_5678, aabb_pkg::COORD_MIN,
                 32'sh0000_0001, -32'sh1234_5678, aabb_pkg::COORD_MAX);
        fill_random(270);
        drain();

        @(negedge aclk);
        send_idle_pct  = 52;
        recv_stall_pct = 20;
        fill_random(290);
        drain();

        @(negedge aclk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fill_random(290);
        drain();

        repeat (20) @(posedge aclk);
        if (expected_bounds.size() != 0) failures++;
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
